// ===== hdl/lac_pkg.sv =====
// ----------------------------------------------------------------------------
// lac_pkg: shared definitions of the layer alpha compositor
// Field widths, checkerboard colors, register codes and the layer color bundle.
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam int unsigned NUM_LAYERS      = 10;
  localparam int unsigned MAX_IMAGE_WIDTH = 4096;

  localparam int unsigned INDEX_W = 24;
  localparam int unsigned WIDTH_W = 13;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned RGB_W   = 24;

  // The index is divided by the width with a fixed number of quotient bits per stage.
  localparam int unsigned DIV_STAGES    = 8;
  localparam int unsigned DIV_STEP_BITS = INDEX_W / DIV_STAGES;

  localparam logic [RGB_W-1:0] BG_LIGHT_RGB = 24'hFFFFFF;
  localparam logic [RGB_W-1:0] BG_DARK_RGB  = 24'hDDDDDD;
  localparam logic [7:0]       BG_ALPHA     = 8'hFF;

  localparam logic [WIDTH_W-1:0]    IMAGE_WIDTH_RST  = 13'd32;
  localparam logic [COUNT_W-1:0]    LAYER_COUNT_RST  = 4'd1;
  localparam logic [NUM_LAYERS-1:0] VISIBLE_MASK_RST = 10'h3FF;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_LAYER_COUNT  = 2'd1,
    CFG_VISIBLE_MASK = 2'd2
  } cfg_reg_e;

  typedef logic [NUM_LAYERS-1:0][COLOR_W-1:0] layer_colors_t;

endpackage

// ===== hdl/lac_bg_divider.sv =====
// ----------------------------------------------------------------------------
// lac_bg_divider: checkerboard background
// Pipelined restoring division of the pixel index by the image width; the
// parity of quotient plus remainder selects the light or dark square.
// ----------------------------------------------------------------------------
module lac_bg_divider (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  logic [lac_pkg::WIDTH_W-1:0]          width_i,
  input  logic [lac_pkg::INDEX_W-1:0]          index_i,
  input  lac_pkg::layer_colors_t               colors_i,
  output logic                                 valid_o,
  output logic [lac_pkg::RGB_W-1:0]            bg_rgb_o,
  output lac_pkg::layer_colors_t               colors_o
);

  localparam int unsigned Stages   = lac_pkg::DIV_STAGES;
  localparam int unsigned StepBits = lac_pkg::DIV_STEP_BITS;
  localparam int unsigned IdxW     = lac_pkg::INDEX_W;
  localparam int unsigned WidthW   = lac_pkg::WIDTH_W;
  localparam logic [WidthW-1:0] MaxWidth = WidthW'(lac_pkg::MAX_IMAGE_WIDTH);

  logic [WidthW-1:0]  width_eff;
  logic [Stages-1:0]  valid_q;
  logic [Stages-1:0]  qbit_q;
  logic [WidthW-1:0]  rem_q    [Stages];
  logic [IdxW-1:0]    idx_q    [Stages-1];
  lac_pkg::layer_colors_t colors_q [Stages];

  // A zero width acts as one, and widths above the maximum are clamped.
  always_comb begin
    if (width_i == '0) begin
      width_eff = WidthW'(1);
    end else if (width_i > MaxWidth) begin
      width_eff = MaxWidth;
    end else begin
      width_eff = width_i;
    end
  end

  // Returns the new remainder and the last quotient bit of a group of steps.
  function automatic logic [WidthW:0] div_steps(input logic [WidthW-1:0]   rem,
                                                input logic [StepBits-1:0] bits,
                                                input logic [WidthW-1:0]   w);
    logic [WidthW-1:0] r;
    logic [WidthW:0]   trial;
    logic              q;
    r = rem;
    q = 1'b0;
    for (int k = StepBits - 1; k >= 0; k--) begin
      trial = {r, bits[k]};
      if (trial >= {1'b0, w}) begin
        r = WidthW'(trial - {1'b0, w});
        q = 1'b1;
      end else begin
        r = trial[WidthW-1:0];
        q = 1'b0;
      end
    end
    return {r, q};
  endfunction

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [WidthW-1:0]      rem_in;
    logic [IdxW-1:0]        idx_in;
    logic                   valid_in;
    lac_pkg::layer_colors_t colors_in;
    logic [WidthW:0]        step_d;

    if (s == 0) begin : g_first
      assign rem_in    = '0;
      assign idx_in    = index_i;
      assign valid_in  = valid_i;
      assign colors_in = colors_i;
    end else begin : g_next
      assign rem_in    = rem_q[s-1];
      assign idx_in    = idx_q[s-1];
      assign valid_in  = valid_q[s-1];
      assign colors_in = colors_q[s-1];
    end

    assign step_d = div_steps(rem_in, idx_in[IdxW-1-s*StepBits -: StepBits], width_eff);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (adv_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]    <= step_d[WidthW:1];
        qbit_q[s]   <= step_d[0];
        colors_q[s] <= colors_in;
      end
    end

    if (s < Stages - 1) begin : g_idx
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          idx_q[s] <= idx_in;
        end
      end
    end
  end

  // Row parity is the last quotient bit, column parity the remainder LSB.
  assign valid_o  = valid_q[Stages-1];
  assign bg_rgb_o = (qbit_q[Stages-1] ^ rem_q[Stages-1][0]) ? lac_pkg::BG_LIGHT_RGB
                                                            : lac_pkg::BG_DARK_RGB;
  assign colors_o = colors_q[Stages-1];

endmodule

// ===== hdl/lac_layer_blend.sv =====
// ----------------------------------------------------------------------------
// lac_layer_blend: source-over blend of one layer
// First stage forms the alpha-weighted products, second stage sums them and
// divides by 255 exactly, or passes the destination through when the layer is disabled.
// ----------------------------------------------------------------------------
module lac_layer_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [lac_pkg::RGB_W-1:0]     dst_i,
  input  logic [lac_pkg::COLOR_W-1:0]   src_i,
  input  lac_pkg::layer_colors_t        colors_i,
  output logic                          valid_o,
  output logic [lac_pkg::RGB_W-1:0]     dst_o,
  output lac_pkg::layer_colors_t        colors_o
);

  localparam int unsigned RgbW = lac_pkg::RGB_W;

  logic [7:0]             alpha;
  logic [7:0]             alpha_inv;
  logic [15:0]            prod_src_d [3];
  logic [15:0]            prod_dst_d [3];
  logic [15:0]            prod_src_q [3];
  logic [15:0]            prod_dst_q [3];
  logic [RgbW-1:0]        dst_a_q;
  lac_pkg::layer_colors_t colors_a_q;
  logic                   valid_a_q;
  logic [RgbW-1:0]        rgb_b_d;
  logic [RgbW-1:0]        rgb_b_q;
  lac_pkg::layer_colors_t colors_b_q;
  logic                   valid_b_q;

  assign alpha     = src_i[7:0];
  assign alpha_inv = 8'hFF - alpha;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_src_d[c] = {8'd0, alpha} * {8'd0, src_i[31-8*c -: 8]};
      prod_dst_d[c] = {8'd0, alpha_inv} * {8'd0, dst_i[23-8*c -: 8]};
    end
  end

  // The sum is at most 255*255, where (x + 1 + x/256) / 256 equals x / 255.
  always_comb begin
    logic [15:0] sum;
    logic [15:0] quo;
    for (int c = 0; c < 3; c++) begin
      sum = prod_src_q[c] + prod_dst_q[c];
      quo = 16'(sum + 16'd1 + {8'd0, sum[15:8]});
      rgb_b_d[23-8*c -: 8] = en_i ? quo[15:8] : dst_a_q[23-8*c -: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (adv_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_src_q <= prod_src_d;
      prod_dst_q <= prod_dst_d;
      dst_a_q    <= dst_i;
      colors_a_q <= colors_i;
      rgb_b_q    <= rgb_b_d;
      colors_b_q <= colors_a_q;
    end
  end

  assign valid_o  = valid_b_q;
  assign dst_o    = rgb_b_q;
  assign colors_o = colors_b_q;

endmodule

// ===== hdl/lac_out_buffer.sv =====
// ----------------------------------------------------------------------------
// lac_out_buffer: output register with skid stage
// Holds the result for the downstream transfer; the skid entry catches the
// one result still in flight when the consumer stalls.
// ----------------------------------------------------------------------------
module lac_out_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [lac_pkg::COLOR_W-1:0]   data_i,
  output logic                          ready_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [lac_pkg::COLOR_W-1:0]   data_o
);

  localparam int unsigned ColorW = lac_pkg::COLOR_W;

  logic              out_valid_q;
  logic              skid_valid_q;
  logic [ColorW-1:0] out_q;
  logic [ColorW-1:0] skid_q;
  logic              push;
  logic              pop;

  assign ready_o = !skid_valid_q;
  assign push    = valid_i && !skid_valid_q;
  assign pop     = out_valid_q && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// ===== hdl/layer_alpha_compositor.sv =====
// ----------------------------------------------------------------------------
// layer_alpha_compositor: checkerboard background with up to ten blended layers
// Each pixel passes the divider stages, the layer stages and the output register.
// Throughput: one pixel per cycle when not stalled; 8 divider stages and 2 stages per layer.
// The whole pipeline holds only while the output skid entry is full.
// Reset clears all valid bits and loads the register defaults; no sweep.
// ----------------------------------------------------------------------------
module layer_alpha_compositor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [lac_pkg::WIDTH_W-1:0]         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lac_pkg::INDEX_W-1:0]         pixel_index_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer0_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer1_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer2_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer3_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer4_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer5_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer6_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer7_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer8_color_i,
  input  logic [lac_pkg::COLOR_W-1:0]         layer9_color_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lac_pkg::COLOR_W-1:0]         composed_color_o
);

  localparam int unsigned NumLayers = lac_pkg::NUM_LAYERS;
  localparam int unsigned CountW    = lac_pkg::COUNT_W;
  localparam int unsigned RgbW      = lac_pkg::RGB_W;

  logic [lac_pkg::WIDTH_W-1:0] image_width_q;
  logic [CountW-1:0]           layer_count_q;
  logic [NumLayers-1:0]        visible_mask_q;

  logic                   pipe_adv;
  lac_pkg::layer_colors_t in_colors;
  logic [NumLayers-1:0]   layer_en;

  logic [NumLayers:0]     chain_valid;
  logic [RgbW-1:0]        chain_rgb    [NumLayers+1];
  lac_pkg::layer_colors_t chain_colors [NumLayers+1];

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= lac_pkg::IMAGE_WIDTH_RST;
      layer_count_q  <= lac_pkg::LAYER_COUNT_RST;
      visible_mask_q <= lac_pkg::VISIBLE_MASK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lac_pkg::CFG_IMAGE_WIDTH: begin
          image_width_q <= cfg_data_i;
        end
        lac_pkg::CFG_LAYER_COUNT: begin
          layer_count_q <= cfg_data_i[CountW-1:0];
        end
        lac_pkg::CFG_VISIBLE_MASK: begin
          visible_mask_q <= cfg_data_i[NumLayers-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A count above the number of layers enables all of them, so no clamp is needed.
  for (genvar i = 0; i < NumLayers; i++) begin : g_en
    assign layer_en[i] = visible_mask_q[i] && (CountW'(i) < layer_count_q);
  end

  always_comb begin
    in_colors[0] = layer0_color_i;
    in_colors[1] = layer1_color_i;
    in_colors[2] = layer2_color_i;
    in_colors[3] = layer3_color_i;
    in_colors[4] = layer4_color_i;
    in_colors[5] = layer5_color_i;
    in_colors[6] = layer6_color_i;
    in_colors[7] = layer7_color_i;
    in_colors[8] = layer8_color_i;
    in_colors[9] = layer9_color_i;
  end

  assign in_ready_o = pipe_adv;

  lac_bg_divider u_bg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (pipe_adv),
    .valid_i  (in_valid_i),
    .width_i  (image_width_q),
    .index_i  (pixel_index_i),
    .colors_i (in_colors),
    .valid_o  (chain_valid[0]),
    .bg_rgb_o (chain_rgb[0]),
    .colors_o (chain_colors[0])
  );

  for (genvar i = 0; i < NumLayers; i++) begin : g_layer
    lac_layer_blend u_blend (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (pipe_adv),
      .en_i     (layer_en[i]),
      .valid_i  (chain_valid[i]),
      .dst_i    (chain_rgb[i]),
      .src_i    (chain_colors[i][i]),
      .colors_i (chain_colors[i]),
      .valid_o  (chain_valid[i+1]),
      .dst_o    (chain_rgb[i+1]),
      .colors_o (chain_colors[i+1])
    );
  end

  // The background alpha is kept, and both checker colors are opaque.
  lac_out_buffer u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[NumLayers]),
    .data_i  ({chain_rgb[NumLayers], lac_pkg::BG_ALPHA}),
    .ready_o (pipe_adv),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (composed_color_o)
  );

  // A full skid entry means the output register is full as well.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_adv |-> out_valid_o)
    else $error("pipeline stalled with an empty output register");

  // The pipeline only stops after a result was refused by the consumer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pipe_adv) |-> $past(out_valid_o && !out_ready_i))
    else $error("pipeline stalled without a refused output transfer");

  // A finished result at the end of the chain is held while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pipe_adv && chain_valid[NumLayers]) |=>
      (chain_valid[NumLayers] && $stable(chain_rgb[NumLayers])))
    else $error("result lost or changed during a stall");

endmodule
